>>> rtl/scbf_pkg.sv
// shared constants, types, the 3-tap box average and argb packing for the filter
// no dependencies
`default_nettype none

package scbf_pkg;

	localparam logic [7:0] ALPHA_BYTE = 8'hFF;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int MAX_PUSH = 2;
	localparam int CHAN_PUTS = 3;

	// reciprocal of 3 in 11 fractional bits, exact for sums up to 765
	localparam logic [10:0] RECIP3 = 11'd683;

	typedef logic [7:0] sample_t;

	typedef struct packed {
		logic [31:0] pixel_argb;
		logic        line_end;
	} result_t;

	function automatic sample_t box3(input sample_t a, input sample_t b, input sample_t c);
		logic [9:0]  s;
		logic [20:0] p;
		s = {2'b00, a} + {2'b00, b} + {2'b00, c};
		p = {11'd0, s} * {10'd0, RECIP3};
		return p[18:11];
	endfunction

	function automatic logic [31:0] pack_pixel(input sample_t r, input sample_t g,
			input sample_t b);
		return {ALPHA_BYTE, r, g, b};
	endfunction

endpackage

`default_nettype wire

>>> rtl/subpixel_cascaded_box_filter.sv
// sub-pixel smoothing filter: two cascaded 3-tap box filters and an argb packer
// depends on scbf_pkg
`default_nettype none

// One 8-bit sub-pixel request is taken per cycle into an input register; the
// whole window update, both box filters and the pixel packing are done
// combinationally on it, and when it advances the resulting 0, 1 or 2 pixels go
// into a four-entry output queue. Throughput is one sample per cycle while
// in_stall is low. The queue sets the rate: in_stall rises only while a sample
// is held and the queue has fewer than two free entries, which happens only
// when the output side stalls. Pixels trail the samples by two sub-pixels, and
// the line_last sample flushes the line, padding missing channels of the final
// pixel with zero and flagging it with line_end.
module subpixel_cascaded_box_filter
	import scbf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  subpixel,
	input  wire logic        line_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      pixel_argb,
	output logic             line_end
);

	// input register
	logic    s1_valid_s1;
	sample_t subpixel_s1;
	logic    line_last_s1;

	// filter state
	sample_t    raw0_q, raw1_q, sm0_q, sm1_q, pc0_q, pc1_q;
	logic [1:0] seen_q, slot_q;

	// output queue
	result_t            fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	logic adv, in_acc, pop;

	// combinational results
	sample_t    a_f, a_end, r0_n, r1_n, s0_n, s1_n, pc0_n, pc1_n;
	logic [1:0] seen_n, slot_n;
	sample_t    ch [CHAN_PUTS];
	logic       chv [CHAN_PUTS];
	result_t    res [MAX_PUSH];
	logic [1:0] push_cnt;

	assign adv      = s1_valid_s1 && (cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_PUSH));
	assign in_stall = s1_valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	assign out_valid  = (cnt_q != '0);
	assign pixel_argb = fifo_q[rd_q].pixel_argb;
	assign line_end   = fifo_q[rd_q].line_end;

	always_comb begin
		sample_t    sv0, sv1, s0, s1;
		logic [1:0] slot;
		logic [1:0] k;
		sv0 = sm0_q;
		sv1 = sm1_q;
		a_f = box3(raw0_q, raw1_q, subpixel_s1);
		for (int i = 0; i < CHAN_PUTS; i++) begin
			ch[i]  = '0;
			chv[i] = 1'b0;
		end
		// first stage window
		if (seen_q == 2'd0) begin
			r0_n = subpixel_s1;
			r1_n = subpixel_s1;
		end else begin
			r0_n = raw1_q;
			r1_n = subpixel_s1;
		end
		// second stage from the regular first-stage value
		s0 = sv0;
		s1 = sv1;
		if (seen_q == 2'd1) begin
			s0 = a_f;
			s1 = a_f;
		end else if (seen_q != 2'd0) begin
			ch[0]  = box3(sv0, sv1, a_f);
			chv[0] = 1'b1;
			s0 = sv1;
			s1 = a_f;
		end
		// line end flush
		a_end = box3(r0_n, r1_n, r1_n);
		if (line_last_s1) begin
			if (seen_q == 2'd0) begin
				s0 = a_end;
				s1 = a_end;
			end else begin
				ch[1]  = box3(s0, s1, a_end);
				chv[1] = 1'b1;
				s0 = s1;
				s1 = a_end;
			end
			ch[2]  = box3(s0, s1, s1);
			chv[2] = 1'b1;
		end
		s0_n = s0;
		s1_n = s1;
		// channel packing
		slot  = slot_q;
		pc0_n = pc0_q;
		pc1_n = pc1_q;
		k     = 2'd0;
		for (int i = 0; i < MAX_PUSH; i++)
			res[i] = '0;
		for (int i = 0; i < CHAN_PUTS; i++) begin
			if (chv[i]) begin
				case (slot)
					2'd0: begin
						pc0_n = ch[i];
						slot  = 2'd1;
					end
					2'd1: begin
						pc1_n = ch[i];
						slot  = 2'd2;
					end
					default: begin
						if (k < 2'd2) begin
							res[k[0]] = '{pixel_argb: pack_pixel(pc0_n, pc1_n, ch[i]),
								line_end: 1'b0};
							k = k + 2'd1;
						end
						slot = 2'd0;
					end
				endcase
			end
		end
		if (line_last_s1) begin
			if (slot != 2'd0 && k < 2'd2) begin
				res[k[0]] = '{pixel_argb: pack_pixel(pc0_n,
					(slot == 2'd2) ? pc1_n : 8'd0, 8'd0), line_end: 1'b0};
				k = k + 2'd1;
			end
			if (k == 2'd1)
				res[0].line_end = 1'b1;
			else if (k == 2'd2)
				res[1].line_end = 1'b1;
			slot   = 2'd0;
			pc0_n  = '0;
			pc1_n  = '0;
			seen_n = 2'd0;
		end else begin
			seen_n = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
		end
		slot_n   = slot;
		push_cnt = k;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_acc) begin
			s1_valid_s1 <= 1'b1;
		end else if (adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			subpixel_s1  <= subpixel;
			line_last_s1 <= line_last;
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw0_q <= '0;
			raw1_q <= '0;
			sm0_q  <= '0;
			sm1_q  <= '0;
			pc0_q  <= '0;
			pc1_q  <= '0;
			seen_q <= '0;
			slot_q <= '0;
		end else if (adv) begin
			raw0_q <= r0_n;
			raw1_q <= r1_n;
			sm0_q  <= s0_n;
			sm1_q  <= s1_n;
			pc0_q  <= pc0_n;
			pc1_q  <= pc1_n;
			seen_q <= seen_n;
			slot_q <= slot_n;
		end
	end

	// output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (adv)
				wr_q <= wr_q + FIFO_AW'(push_cnt);
			if (pop)
				rd_q <= rd_q + FIFO_AW'(1);
			cnt_q <= cnt_q + ((adv) ? (FIFO_AW+1)'(push_cnt) : '0)
				- (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (push_cnt != 2'd0)
				fifo_q[wr_q] <= res[0];
			if (push_cnt == 2'd2)
				fifo_q[wr_q + FIFO_AW'(1)] <= res[1];
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("output queue overflow");

	a_one_per_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !line_last_s1) |-> (push_cnt <= 2'd1))
		else $error("more than one pixel from a mid-line sample");

	a_end_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !line_last_s1) |-> !res[0].line_end)
		else $error("line_end on a mid-line sample");

	a_flush_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && line_last_s1) |-> (push_cnt != 2'd0))
		else $error("line end produced no pixel");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && line_last_s1) |=> (seen_q == 2'd0 && slot_q == 2'd0))
		else $error("line state not cleared after flush");

endmodule

`default_nettype wire
